>>> src/tcce_pkg.sv
// Package for the text console character engine.
// Holds the function and character codes, the controller state type and
// the command and status words that pass between controller and datapath.
package tcce_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam int          TAB_STEP   = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_put;
    logic home;
    logic read;
    logic cnt_zero;
    logic copy_rd;
    logic fill;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       need_scroll;
    logic       scroll_last;
    logic       fill_last;
    logic       out_free;
  } status_t;

endpackage

>>> src/tcce_if.sv
// Channel interfaces for the text console character engine.
// One carries request words, the other result words; no dependencies.
interface tcce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  char_code;
  logic [3:0]  bg_colour;
  logic [3:0]  fg_colour;
  logic [10:0] cell_address;

  modport source (output valid, func, char_code, bg_colour, fg_colour, cell_address,
                  input ready);
  modport sink (input valid, func, char_code, bg_colour, fg_colour, cell_address,
                output ready);
endinterface

interface tcce_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_location;
  logic [15:0] read_data;

  modport source (output valid, cursor_location, read_data, input ready);
  modport sink (input valid, cursor_location, read_data, output ready);
endinterface

>>> src/text_console_char_engine.sv
// Text console character engine: top level joining controller and datapath.
// Depends on tcce_pkg, the channel interfaces, tcce_ctrl and tcce_datapath.
//
// A character put, a read or an unused function code is taken in the idle
// step, executed in the next cycle and then loaded into the result register
// in the done step once that register is free; a new request word is only
// taken after the last has left the done step. A put that moves the cursor
// past the last row copies the store up one cell per cycle and then blanks
// the bottom row before its result word is loaded; a clear walks the whole
// store before its result is loaded. After reset a clearing pass blanks the
// store before the first word is taken. A finished result waits in an output
// register, so the next request word is taken while it is still unread; the
// controller only stalls when a second result is ready before the first has
// been read.
module text_console_char_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic       clk,
  input logic       rst,
  tcce_in_if.sink   req,
  tcce_out_if.source rsp
);

  tcce_pkg::cmd_t    cmd;
  tcce_pkg::status_t st;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .in_func             (req.func),
    .in_char_code        (req.char_code),
    .in_bg_colour        (req.bg_colour),
    .in_fg_colour        (req.fg_colour),
    .in_cell_address     (req.cell_address),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_cursor_location (rsp.cursor_location),
    .out_read_data       (rsp.read_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("Request accepted while the previous word was still in work.");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("Result register loaded while an unread word was held.");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.out_load))
    else $error("Result word appeared without a load from the controller.");

  a_no_load_while_accepting: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.out_load && !cmd.fill && !cmd.copy_rd)
    else $error("Request taken while the store or result path was busy.");

endmodule

>>> src/tcce_ctrl.sv
// Controller state machine of the text console character engine.
// Depends on tcce_pkg for the state type and the command and status words.
module tcce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcce_pkg::status_t st,
  output tcce_pkg::cmd_t    cmd
);

  tcce_pkg::state_t state;
  tcce_pkg::state_t state_next;
  logic             reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcce_pkg::ST_FILL;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcce_pkg::ST_EXEC) begin
        reply <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcce_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        unique case (st.func)
          tcce_pkg::FUNC_PUT: begin
            state_next = st.need_scroll ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_DONE;
          end
          tcce_pkg::FUNC_CLEAR: state_next = tcce_pkg::ST_FILL;
          default:              state_next = tcce_pkg::ST_DONE;
        endcase
      end
      tcce_pkg::ST_SCROLL: begin
        if (st.scroll_last) begin
          state_next = tcce_pkg::ST_FILL;
        end
      end
      tcce_pkg::ST_FILL: begin
        if (st.fill_last) begin
          state_next = reply ? tcce_pkg::ST_DONE : tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_DONE: begin
        if (st.out_free) begin
          state_next = tcce_pkg::ST_IDLE;
        end
      end
      default: state_next = tcce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      tcce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tcce_pkg::ST_EXEC: begin
        unique case (st.func)
          tcce_pkg::FUNC_PUT: begin
            cmd.exec_put = 1'b1;
            cmd.cnt_zero = 1'b1;
          end
          tcce_pkg::FUNC_CLEAR: begin
            cmd.home     = 1'b1;
            cmd.cnt_zero = 1'b1;
          end
          tcce_pkg::FUNC_READ: cmd.read = 1'b1;
          default: ;
        endcase
      end
      tcce_pkg::ST_SCROLL: cmd.copy_rd = !st.scroll_last;
      tcce_pkg::ST_FILL:   cmd.fill = 1'b1;
      tcce_pkg::ST_DONE:   cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule

>>> src/tcce_datapath.sv
// Datapath of the text console character engine: request register, cursor,
// screen store, scroll and fill address counter and the result register.
// Depends on tcce_pkg for codes and the command and status words.
module tcce_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  tcce_pkg::cmd_t    cmd,
  output tcce_pkg::status_t st,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_bg_colour,
  input  logic [3:0]        in_fg_colour,
  input  logic [10:0]       in_cell_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [10:0]       out_cursor_location,
  output logic [15:0]       out_read_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [1:0]    it_func;
  logic [7:0]    it_code;
  logic [3:0]    it_back;
  logic [3:0]    it_fore;
  logic [10:0]   it_addr;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW:0]   col_a;
  logic [CW:0]   col_b;
  logic [RW:0]   row_a;
  logic [RW:0]   row_b;
  logic          is_print;
  logic          need_scroll;
  logic [AW-1:0] cur_idx;
  logic          addr_ok;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] cnt;
  logic          copy_v;
  logic [AW-1:0] copy_addr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_func <= in_func;
      it_code <= in_char_code;
      it_back <= in_bg_colour;
      it_fore <= in_fg_colour;
      it_addr <= in_cell_address;
    end
  end

  always_comb begin
    col_a    = (CW + 1)'(col);
    row_a    = (RW + 1)'(row);
    is_print = 1'b0;
    case (it_code) inside
      tcce_pkg::CHAR_BS: begin
        if (col != '0) begin
          col_a = (CW + 1)'(col) - (CW + 1)'(1);
        end
      end
      tcce_pkg::CHAR_TAB: begin
        col_a = ((CW + 1)'(col) + (CW + 1)'(tcce_pkg::TAB_STEP))
                & ~(CW + 1)'(tcce_pkg::TAB_STEP - 1);
      end
      tcce_pkg::CHAR_CR: col_a = '0;
      tcce_pkg::CHAR_LF: begin
        col_a = '0;
        row_a = (RW + 1)'(row) + (RW + 1)'(1);
      end
      [tcce_pkg::CHAR_PRINT_LO:tcce_pkg::CHAR_PRINT_HI]: begin
        is_print = 1'b1;
        col_a    = (CW + 1)'(col) + (CW + 1)'(1);
      end
      default: ;
    endcase
    col_b = col_a;
    row_b = row_a;
    if (col_a >= (CW + 1)'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + (RW + 1)'(1);
    end
    need_scroll = row_b >= (RW + 1)'(ROWS);
  end

  assign cur_idx = AW'(AW'(row) * AW'(COLUMNS)) + AW'(col);
  assign addr_ok = 32'(it_addr) < 32'(CELLS);

  always_ff @(posedge clk) begin
    if (rst || cmd.home) begin
      col <= '0;
      row <= '0;
    end else if (cmd.exec_put) begin
      col <= CW'(col_b);
      row <= need_scroll ? RW'(ROWS - 1) : RW'(row_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_zero) begin
      cnt <= '0;
    end else if (cmd.copy_rd || cmd.fill) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_v <= 1'b0;
    end else begin
      copy_v <= cmd.copy_rd;
    end
    copy_addr <= cnt;
  end

  assign rd_en = cmd.read || cmd.copy_rd;
  assign raddr = cmd.copy_rd ? cnt + AW'(COLUMNS) : AW'(it_addr);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = tcce_pkg::BLANK_CELL;
    if (copy_v) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rdata;
    end else if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.exec_put && is_print) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = {it_back, it_fore, it_code};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cursor_location <= 11'(cur_idx);
      out_read_data       <= (it_func == tcce_pkg::FUNC_READ && addr_ok) ? rdata : 16'h0000;
    end
  end

  assign st.func        = it_func;
  assign st.need_scroll = need_scroll;
  assign st.scroll_last = cnt == AW'(CELLS - COLUMNS);
  assign st.fill_last   = cnt == AW'(CELLS - 1);
  assign st.out_free    = !out_valid || out_ready;

endmodule

>>> verif/text_console_char_engine_check.sv
`timescale 1ns / 100ps
// Checker for the text console character engine: keeps its own screen and cursor,
// predicts each result word from the accepted request words and compares them.
// Depends on tcce_pkg and the channel interfaces tcce_in_if and tcce_out_if.
module text_console_char_engine_check #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst,
  tcce_in_if   req,
  tcce_out_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [15:0] read_data;
  } console_word_t;

  logic [15:0]   screen [CELLS];
  logic [6:0]    cur_col;
  logic [4:0]    cur_row;
  console_word_t predicted_words [$];

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = tcce_pkg::BLANK_CELL;
  endfunction

  function automatic console_word_t console_update(logic [1:0] f, logic [7:0] code,
                                                  logic [3:0] bg, logic [3:0] fg,
                                                  logic [10:0] addr);
    console_word_t w;
    int            idx;
    w.read_data = '0;
    case (f)
      tcce_pkg::FUNC_PUT: begin
        case (code)
          tcce_pkg::CHAR_BS: begin
            if (cur_col != 0) cur_col = cur_col - 7'd1;
          end
          tcce_pkg::CHAR_TAB: begin
            cur_col = (cur_col + 7'(tcce_pkg::TAB_STEP)) & ~7'(tcce_pkg::TAB_STEP - 1);
          end
          tcce_pkg::CHAR_CR: cur_col = '0;
          tcce_pkg::CHAR_LF: begin
            cur_col = '0;
            cur_row = cur_row + 5'd1;
          end
          default: begin
            if (code >= tcce_pkg::CHAR_PRINT_LO && code <= tcce_pkg::CHAR_PRINT_HI) begin
              idx = cur_row * COLUMNS + cur_col;
              if (idx < CELLS) screen[idx] = {bg, fg, code};
              cur_col = cur_col + 7'd1;
            end
          end
        endcase
        if (cur_col >= COLUMNS) begin
          cur_col = '0;
          cur_row = cur_row + 5'd1;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = tcce_pkg::BLANK_CELL;
          cur_row = 5'(ROWS - 1);
        end
      end
      tcce_pkg::FUNC_CLEAR: begin
        blank_screen();
        cur_col = '0;
        cur_row = '0;
      end
      tcce_pkg::FUNC_READ: begin
        if (addr < CELLS) w.read_data = screen[addr];
      end
      default: ;
    endcase
    w.cursor_location = 11'(cur_row * COLUMNS + cur_col);
    return w;
  endfunction

  always @(posedge clk) begin
    console_word_t got;
    console_word_t want;
    if (rst) begin
      blank_screen();
      cur_col = '0;
      cur_row = '0;
      predicted_words.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.cursor_location = rsp.cursor_location;
        got.read_data       = rsp.read_data;
        if (predicted_words.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected result word, cursor %0d data %h", $realtime,
                     got.cursor_location, got.read_data);
        end else begin
          want = predicted_words.pop_front();
          if (got.cursor_location !== want.cursor_location ||
              got.read_data !== want.read_data) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: cursor expected %0d got %0d, data expected %h got %h",
                       $realtime, want.cursor_location, got.cursor_location,
                       want.read_data, got.read_data);
          end
        end
      end
      if (req.valid && req.ready)
        predicted_words.push_back(console_update(req.func, req.char_code, req.bg_colour,
                                                 req.fg_colour, req.cell_address));
    end
    outstanding = predicted_words.size();
  end

endmodule

>>> verif/text_console_char_engine_tb.sv
`timescale 1ns / 100ps
// Testbench top for the text console character engine: drives request words with
// random gaps and result stalls, and gives the verdict from the checker's count.
// Depends on tcce_pkg, the channel interfaces, the block and its checker.
module text_console_char_engine_tb;

  localparam int          COLUMNS      = 80;
  localparam int          ROWS         = 25;
  localparam int          CELLS        = COLUMNS * ROWS;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [7:0]  CHAR_NUL     = 8'h00;
  localparam logic [7:0]  CHAR_US      = 8'h1F;
  localparam logic [7:0]  CHAR_HIGH_LO = 8'h80;
  localparam logic [7:0]  CHAR_HIGH_HI = 8'hFF;
  localparam int          TOTAL_WORDS  = 1150;
  localparam longint      CYCLE_LIMIT  = 10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        steady = 1'b0;
  logic [10:0] last_cursor = '0;
  int          mismatches;
  int          outstanding;
  int          words_done = 0;
  int          stall_left = 0;
  longint      cycles = 0;

  tcce_in_if  req_ch ();
  tcce_out_if rsp_ch ();

  text_console_char_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  text_console_char_engine_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) last_cursor <= rsp_ch.cursor_location;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(tcce_pkg::CHAR_PRINT_LO, tcce_pkg::CHAR_PRINT_HI));
  endfunction

  function automatic bit has_effect(logic [1:0] f, logic [7:0] code);
    if (f == FUNC_UNUSED) return 1'b0;
    if (f != tcce_pkg::FUNC_PUT) return 1'b1;
    return code == tcce_pkg::CHAR_BS || code == tcce_pkg::CHAR_TAB ||
           code == tcce_pkg::CHAR_CR || code == tcce_pkg::CHAR_LF ||
           (code >= tcce_pkg::CHAR_PRINT_LO && code <= tcce_pkg::CHAR_PRINT_HI);
  endfunction

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = idle_length();
      end
    end
  end

  task automatic send_word(logic [1:0] f, logic [7:0] code, logic [3:0] bg, logic [3:0] fg,
                           logic [10:0] addr);
    int gap;
    gap = idle_length();
    if ($urandom_range(0, 79) == 0) steady = ~steady;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.func         = f;
    req_ch.char_code    = code;
    req_ch.bg_colour    = bg;
    req_ch.fg_colour    = fg;
    req_ch.cell_address = addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (has_effect(f, code)) words_done++;
  endtask

  task automatic put_char(logic [7:0] code);
    send_word(tcce_pkg::FUNC_PUT, code, 4'($urandom), 4'($urandom), 11'($urandom));
  endtask

  task automatic read_cell(logic [10:0] addr);
    send_word(tcce_pkg::FUNC_READ, 8'($urandom), 4'($urandom), 4'($urandom), addr);
  endtask

  task automatic read_near_cursor();
    int offset;
    offset = $urandom_range(0, 2 * COLUMNS);
    read_cell(11'((last_cursor >= offset) ? last_cursor - offset : 0));
  endtask

  task automatic read_any();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) read_near_cursor();
    else if (r < 90) read_cell(11'($urandom_range(0, CELLS - 1)));
    else read_cell(11'($urandom_range(0, 2047)));
  endtask

  task automatic send_line();
    int len;
    int r;
    len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 24) : $urandom_range(70, 100);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) put_char(tcce_pkg::CHAR_TAB);
      else if (r < 12) put_char(tcce_pkg::CHAR_BS);
      else put_char(rand_printable());
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      put_char(tcce_pkg::CHAR_LF);
    end else if (r < 80) begin
      put_char(tcce_pkg::CHAR_CR);
      put_char(tcce_pkg::CHAR_LF);
    end
    read_near_cursor();
    read_near_cursor();
  endtask

  task automatic send_single();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) put_char(rand_printable());
    else if (r < 36) put_char(tcce_pkg::CHAR_TAB);
    else if (r < 40) put_char(tcce_pkg::CHAR_CR);
    else if (r < 45) put_char(tcce_pkg::CHAR_BS);
    else if (r < 48) put_char(8'($urandom_range(CHAR_NUL, CHAR_US)));
    else if (r < 51) put_char(8'($urandom_range(CHAR_HIGH_LO, CHAR_HIGH_HI)));
    else if (r < 53) send_word(FUNC_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom),
                               11'($urandom));
    else read_any();
  endtask

  initial begin
    int r;
    req_ch.valid        = 1'b0;
    req_ch.func         = tcce_pkg::FUNC_PUT;
    req_ch.char_code    = CHAR_NUL;
    req_ch.bg_colour    = '0;
    req_ch.fg_colour    = '0;
    req_ch.cell_address = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    read_cell(11'd0);
    put_char(tcce_pkg::CHAR_BS);
    send_word(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_PRINT_LO, 4'h0, 4'h0, 11'd0);
    send_word(tcce_pkg::FUNC_PUT, tcce_pkg::CHAR_PRINT_HI, 4'hF, 4'hF, 11'h7FF);
    send_word(tcce_pkg::FUNC_PUT, 8'h41, 4'hA, 4'h5, 11'h555);
    put_char(tcce_pkg::CHAR_BS);
    put_char(tcce_pkg::CHAR_TAB);
    put_char(tcce_pkg::CHAR_TAB);
    put_char(tcce_pkg::CHAR_CR);
    put_char(CHAR_NUL);
    put_char(CHAR_US);
    put_char(CHAR_HIGH_LO);
    put_char(CHAR_HIGH_HI);
    send_word(FUNC_UNUSED, CHAR_HIGH_HI, 4'hF, 4'hF, 11'd0);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    put_char(tcce_pkg::CHAR_LF);
    send_word(tcce_pkg::FUNC_CLEAR, CHAR_HIGH_HI, 4'hF, 4'hF, 11'h7FF);
    read_cell(11'd1);

    while (words_done < TOTAL_WORDS) begin
      if ($urandom_range(0, 299) == 0)
        send_word(tcce_pkg::FUNC_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                  11'($urandom));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_line();
      end else if (r < 45) begin
        repeat ($urandom_range(1, 6)) put_char(tcce_pkg::CHAR_LF);
      end else begin
        send_single();
      end
    end
    req_ch.valid = 1'b0;

    wait (outstanding == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
